// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLQB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TLQB_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TLQB_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLQB_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/tlqb_pkg.sv -----
// Types, widths and helpers for the thick line quad builder.
// No dependencies.
package tlqb_pkg;

  localparam int MAX_LINES = 16384;
  localparam int LC_W      = $clog2(MAX_LINES);
  localparam int IN_W      = 16;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SC_W      = 29;  // scaled coordinate, Q.14
  localparam int AB_W      = 29;  // magnitude of a difference
  localparam int SQ_W      = 2 * AB_W;
  localparam int RT_W      = 60;  // root working width
  localparam int MAG_W     = 30;
  localparam int DV_W      = 36;  // divider working width
  localparam int Q_W       = 5;   // quotient, at most 16
  localparam int P_W       = 6;   // signed perpendicular
  localparam int BQ_W      = 20;  // rounded endpoint, Q.4
  localparam int OUT_W     = 19;
  localparam int IDX_W     = 16;
  localparam int CNT_W     = 3;
  localparam int DIV_STEPS = 5;
  localparam int ROOT_START = 58;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     MAP_RESET      = CFG_W'(512);

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  typedef enum logic [2:0] {
    SLOT_V0, SLOT_V1, SLOT_V2, SLOT_V3, SLOT_T0, SLOT_T1
  } tlqb_slot_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_DIFF, ST_SQUARE, ST_ROOT_INIT, ST_ROOT,
    ST_DIV_INIT_X, ST_DIV_X, ST_DIV_INIT_Y, ST_DIV_Y, ST_EMIT
  } tlqb_state_e;

  typedef struct packed {
    logic       load;
    logic       scale;
    logic       diff;
    logic       square;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_sel_y;
    logic       div_step;
    logic       div_last;
    logic       clr_perp;
    tlqb_slot_e slot;
  } tlqb_cmd_t;

  typedef struct packed {
    logic root_last;
    logic mag_zero;
  } tlqb_sts_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [BQ_W:0] v);
    logic signed [BQ_W:0] hi;
    logic signed [BQ_W:0] lo;
    hi = (BQ_W+1)'((1 <<< (OUT_W-1)) - 1);
    lo = -(BQ_W+1)'(1 <<< (OUT_W-1));
    if (v > hi) begin
      return hi[OUT_W-1:0];
    end else if (v < lo) begin
      return lo[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// ----- rtl/tlqb_if.sv -----
// Request channel interfaces for segment input and vertex/triangle output.
// Depends on tlqb_pkg for widths.
interface tlqb_in_if;
  import tlqb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  src_x;
  logic signed [IN_W-1:0]  src_y;
  logic signed [IN_W-1:0]  dst_x;
  logic signed [IN_W-1:0]  dst_y;
  logic                    new_mesh;
  modport source (output valid, src_x, src_y, dst_x, dst_y, new_mesh, input ready);
  modport sink   (input valid, src_x, src_y, dst_x, dst_y, new_mesh, output ready);
endinterface

interface tlqb_out_if;
  import tlqb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [OUT_W-1:0] vertex_x;
  logic signed [OUT_W-1:0] vertex_y;
  logic                    tex_u;
  logic                    tex_v;
  logic [IDX_W-1:0]        index_a;
  logic [IDX_W-1:0]        index_b;
  logic [IDX_W-1:0]        index_c;
  logic                    last;
  modport source (output valid, kind, vertex_x, vertex_y, tex_u, tex_v,
                  index_a, index_b, index_c, last, input ready);
  modport sink   (input valid, kind, vertex_x, vertex_y, tex_u, tex_v,
                  index_a, index_b, index_c, last, output ready);
endinterface

// ----- rtl/tlqb_ctrl.sv -----
// Sequencer for the quad builder: walks scale, root, divide and emit phases.
// Depends on tlqb_pkg.
module tlqb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tlqb_pkg::tlqb_sts_t sts_i,
  output tlqb_pkg::tlqb_cmd_t cmd_o
);
  import tlqb_pkg::*;

  tlqb_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.slot  = tlqb_slot_e'(cnt_q);
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = ST_DIV_INIT_X;
        end
      end
      ST_DIV_INIT_X: begin
        cnt_d = '0;
        if (sts_i.mag_zero) begin
          cmd_o.clr_perp = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV_X;
        end
      end
      ST_DIV_X, ST_DIV_Y: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_sel_y = (state_q == ST_DIV_Y);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cmd_o.div_last = 1'b1;
          cnt_d          = '0;
          state_d        = (state_q == ST_DIV_Y) ? ST_EMIT : ST_DIV_INIT_Y;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV_INIT_Y: begin
        cmd_o.div_init  = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_d         = ST_DIV_Y;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (tlqb_slot_e'(cnt_q) == SLOT_T1) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

endmodule

// ----- rtl/tlqb_dp.sv -----
// Datapath: scaling, bit-serial root, shared restoring divider, result mux.
// Depends on tlqb_pkg.
module tlqb_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlqb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tlqb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic signed [tlqb_pkg::IN_W-1:0] src_x_i,
  input  logic signed [tlqb_pkg::IN_W-1:0] src_y_i,
  input  logic signed [tlqb_pkg::IN_W-1:0] dst_x_i,
  input  logic signed [tlqb_pkg::IN_W-1:0] dst_y_i,
  input  logic                           new_mesh_i,
  input  tlqb_pkg::tlqb_cmd_t            cmd_i,
  output tlqb_pkg::tlqb_sts_t            sts_o,
  output logic                           kind_o,
  output logic signed [tlqb_pkg::OUT_W-1:0] vertex_x_o,
  output logic signed [tlqb_pkg::OUT_W-1:0] vertex_y_o,
  output logic                           tex_u_o,
  output logic                           tex_v_o,
  output logic [tlqb_pkg::IDX_W-1:0]     index_a_o,
  output logic [tlqb_pkg::IDX_W-1:0]     index_b_o,
  output logic [tlqb_pkg::IDX_W-1:0]     index_c_o,
  output logic                           last_o
);
  import tlqb_pkg::*;

  logic [CFG_W-1:0]        map_w_q, map_h_q;
  logic [LC_W-1:0]         lc_q, lc_base;
  logic [IDX_W-1:0]        vbase_q;
  logic signed [IN_W-1:0]  in_sx_q, in_sy_q, in_tx_q, in_ty_q;
  logic signed [SC_W-1:0]  sx_q, sy_q, tx_q, ty_q;
  logic [AB_W-1:0]         adx_q, ady_q;
  logic                    dx_neg_q, dy_pos_q;
  logic signed [BQ_W-1:0]  bqx_q, bqy_q, tqx_q, tqy_q;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic [RT_W-1:0]         rn_q, res_q, bit_q;
  logic [DV_W-1:0]         num_q, dsh_q;
  logic [Q_W-1:0]          q_q;
  logic signed [P_W-1:0]   px_q, py_q;

  // Scale: signed coordinate times unsigned map size
  logic signed [IN_W+CFG_W:0] p_sx, p_sy, p_tx, p_ty;
  assign p_sx = in_sx_q * $signed({1'b0, map_w_q});
  assign p_tx = in_tx_q * $signed({1'b0, map_w_q});
  assign p_sy = in_sy_q * $signed({1'b0, map_h_q});
  assign p_ty = in_ty_q * $signed({1'b0, map_h_q});

  logic signed [SC_W:0] dx_w, dy_w;
  assign dx_w = $signed({tx_q[SC_W-1], tx_q}) - $signed({sx_q[SC_W-1], sx_q});
  assign dy_w = $signed({ty_q[SC_W-1], ty_q}) - $signed({sy_q[SC_W-1], sy_q});

  logic [SC_W:0] adx_w, ady_w;
  assign adx_w = dx_w[SC_W] ? -dx_w : dx_w;
  assign ady_w = dy_w[SC_W] ? -dy_w : dy_w;

  // round half up: floor((v + 512) / 1024)
  function automatic logic signed [BQ_W-1:0] rnd(input logic signed [SC_W-1:0] v);
    logic signed [SC_W:0] s;
    s = $signed({v[SC_W-1], v}) + (SC_W+1)'(512);
    return s[SC_W:10];
  endfunction

  // root step
  logic [RT_W-1:0] trial;
  logic            take;
  assign trial = res_q + bit_q;
  assign take  = (rn_q >= trial);

  // divider step
  logic            dtake;
  logic [Q_W-1:0]  q_fin;
  logic [MAG_W-1:0] mag;
  assign mag   = res_q[MAG_W-1:0];
  assign dtake = (num_q >= dsh_q);
  assign q_fin = {q_q[Q_W-2:0], dtake};

  logic signed [P_W-1:0] q_pos, q_neg;
  assign q_pos = $signed({1'b0, q_fin});
  assign q_neg = -q_pos;

  assign sts_o.root_last = bit_q[0];
  assign sts_o.mag_zero  = (res_q == '0);

  assign lc_base = new_mesh_i ? '0 : lc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= MAP_RESET;
      map_h_q <= MAP_RESET;
      lc_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_MAP_WIDTH) begin
        map_w_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_MAP_HEIGHT) begin
        map_h_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        lc_q <= (lc_base == LC_W'(MAX_LINES - 1)) ? '0 : lc_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_sx_q <= src_x_i;
      in_sy_q <= src_y_i;
      in_tx_q <= dst_x_i;
      in_ty_q <= dst_y_i;
      vbase_q <= IDX_W'({lc_base, 2'b00});
    end
    if (cmd_i.scale) begin
      sx_q <= p_sx[SC_W-1:0];
      sy_q <= p_sy[SC_W-1:0];
      tx_q <= p_tx[SC_W-1:0];
      ty_q <= p_ty[SC_W-1:0];
    end
    if (cmd_i.diff) begin
      adx_q    <= adx_w[AB_W-1:0];
      ady_q    <= ady_w[AB_W-1:0];
      dx_neg_q <= dx_w[SC_W];
      dy_pos_q <= !dy_w[SC_W] && (dy_w != '0);
      bqx_q    <= rnd(sx_q);
      bqy_q    <= rnd(sy_q);
      tqx_q    <= rnd(tx_q);
      tqy_q    <= rnd(ty_q);
    end
    if (cmd_i.square) begin
      sqx_q <= adx_q * adx_q;
      sqy_q <= ady_q * ady_q;
    end
    if (cmd_i.root_init) begin
      rn_q  <= RT_W'(sqx_q) + RT_W'(sqy_q);
      res_q <= '0;
      bit_q <= RT_W'(1) << ROOT_START;
    end
    if (cmd_i.root_step) begin
      if (take) begin
        rn_q  <= rn_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      // numerator 2*16*|d| + mag, divisor 2*mag aligned to the top quotient bit
      num_q <= (cmd_i.div_sel_y ? (DV_W'(adx_q) << 5) : (DV_W'(ady_q) << 5)) + DV_W'(mag);
      dsh_q <= DV_W'(mag) << 5;
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (dtake) begin
        num_q <= num_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      q_q   <= q_fin;
      if (cmd_i.div_last) begin
        if (cmd_i.div_sel_y) begin
          py_q <= dx_neg_q ? q_neg : q_pos;
        end else begin
          px_q <= dy_pos_q ? q_neg : q_pos;
        end
      end
    end
    if (cmd_i.clr_perp) begin
      px_q <= '0;
      py_q <= '0;
    end
  end

  // Result selection
  logic signed [BQ_W:0] ex, ey, pxe, pye;
  logic signed [BQ_W-1:0] qx, qy;
  logic sub;
  assign pxe = (BQ_W+1)'(px_q);
  assign pye = (BQ_W+1)'(py_q);

  always_comb begin
    kind_o    = KIND_VERTEX;
    tex_u_o   = 1'b0;
    tex_v_o   = 1'b0;
    index_a_o = vbase_q;
    index_b_o = '0;
    index_c_o = '0;
    last_o    = 1'b0;
    qx        = bqx_q;
    qy        = bqy_q;
    sub       = 1'b0;
    case (cmd_i.slot)
      SLOT_V0: begin
      end
      SLOT_V1: begin
        sub       = 1'b1;
        tex_u_o   = 1'b1;
        index_a_o = vbase_q + IDX_W'(1);
      end
      SLOT_V2: begin
        qx        = tqx_q;
        qy        = tqy_q;
        tex_v_o   = 1'b1;
        index_a_o = vbase_q + IDX_W'(2);
      end
      SLOT_V3: begin
        qx        = tqx_q;
        qy        = tqy_q;
        sub       = 1'b1;
        tex_u_o   = 1'b1;
        tex_v_o   = 1'b1;
        index_a_o = vbase_q + IDX_W'(3);
      end
      SLOT_T0: begin
        kind_o    = KIND_TRI;
        index_b_o = vbase_q + IDX_W'(1);
        index_c_o = vbase_q + IDX_W'(2);
      end
      SLOT_T1: begin
        kind_o    = KIND_TRI;
        index_a_o = vbase_q + IDX_W'(2);
        index_b_o = vbase_q + IDX_W'(1);
        index_c_o = vbase_q + IDX_W'(3);
        last_o    = 1'b1;
      end
      default: begin
      end
    endcase
    ex = sub ? ($signed({qx[BQ_W-1], qx}) - pxe) : ($signed({qx[BQ_W-1], qx}) + pxe);
    ey = sub ? ($signed({qy[BQ_W-1], qy}) - pye) : ($signed({qy[BQ_W-1], qy}) + pye);
    if (kind_o == KIND_TRI) begin
      vertex_x_o = '0;
      vertex_y_o = '0;
    end else begin
      vertex_x_o = sat_out(ex);
      vertex_y_o = sat_out(ey);
    end
  end

endmodule

// ----- rtl/thick_line_quad_builder_top.sv -----
// Top level of the thick line quad builder.
// Depends on tlqb_pkg, tlqb_if, tlqb_ctrl, tlqb_dp and assert_macros.svh.
//
// Usage
// - in_if carries one line segment per request (Q2.14 endpoints, new_mesh).
//   out_if returns six requests per segment: four vertices (Q15.4, texture
//   corners 00,10,01,11) then two triangles; last marks the sixth.
// - cfg_we_i/cfg_idx_i/cfg_data_i write map_width (index 0) or map_height
//   (index 1); other indexes are dropped. Write only while the block is idle.
// - Sequence: once the input request is taken, the block steps through scale,
//   difference, square, root set-up, a 30-step bit-serial square root, and
//   two 5-step restoring divisions (each with a set-up step) on one shared
//   divider before the first result is valid. A zero-length segment skips
//   the divisions.
// - Flow: the next request is taken only after the six results of a segment
//   have all been taken and the block is back in idle. in_if.ready is high
//   only when no segment is in flight.
// - Stall: results are held stable until out_if.ready; the block simply waits.
// - Reset: map sizes return to 512, the line counter to zero, no request
//   pending on either channel.
`include "assert_macros.svh"

module thick_line_quad_builder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlqb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tlqb_pkg::CFG_W-1:0]     cfg_data_i,
  tlqb_in_if.sink                        in_if,
  tlqb_out_if.source                     out_if
);
  import tlqb_pkg::*;

  tlqb_cmd_t cmd;
  tlqb_sts_t sts;

  tlqb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlqb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .src_x_i    (in_if.src_x),
    .src_y_i    (in_if.src_y),
    .dst_x_i    (in_if.dst_x),
    .dst_y_i    (in_if.dst_y),
    .new_mesh_i (in_if.new_mesh),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .kind_o     (out_if.kind),
    .vertex_x_o (out_if.vertex_x),
    .vertex_y_o (out_if.vertex_y),
    .tex_u_o    (out_if.tex_u),
    .tex_v_o    (out_if.tex_v),
    .index_a_o  (out_if.index_a),
    .index_b_o  (out_if.index_b),
    .index_c_o  (out_if.index_c),
    .last_o     (out_if.last)
  );

  // one segment in flight: no new request while results are pending
  `TLQB_NEVER(a_no_overlap, clk_i, rst_ni, in_if.ready && out_if.valid, "input open during emit")
  // taking a segment closes the input
  `TLQB_ASSERT(a_accept_closes, clk_i, rst_ni, (in_if.valid && in_if.ready) |=> !in_if.ready, "input still open")
  // the final result ends the burst
  `TLQB_ASSERT(a_last_ends, clk_i, rst_ni, (out_if.valid && out_if.ready && out_if.last) |=> !out_if.valid, "results after last")
  // triangles carry no position
  `TLQB_ASSERT(a_tri_zero, clk_i, rst_ni, (out_if.valid && out_if.kind == KIND_TRI) |-> (out_if.vertex_x == '0 && out_if.vertex_y == '0), "triangle with position")

endmodule
